@@ rtl/lmss_pkg.sv @@
// Package for the LED marquee speed selector.
// Holds the shared types, register indexes and the digit glyph table.
// No dependencies; used by every other file of the block.
package lmss_pkg;

  localparam int unsigned REG_W     = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_SPEED = 4;
  localparam int unsigned POS_W     = 3;
  localparam int unsigned SPEED_W   = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] IDX_SPEED_PERIOD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] IDX_SPEED_PERIOD_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] IDX_SPEED_PERIOD_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_SPEED_PERIOD_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] IDX_BLINK_PERIOD   = 3'd4;

  localparam logic [REG_W-1:0] RST_SPEED_PERIOD_0 = 8'd5;
  localparam logic [REG_W-1:0] RST_SPEED_PERIOD_1 = 8'd10;
  localparam logic [REG_W-1:0] RST_SPEED_PERIOD_2 = 8'd20;
  localparam logic [REG_W-1:0] RST_SPEED_PERIOD_3 = 8'd2;
  localparam logic [REG_W-1:0] RST_BLINK_PERIOD   = 8'd3;

  localparam logic [7:0] LEDS_OFF  = 8'hff;
  localparam logic [7:0] LED_PAIR  = 8'h03;
  localparam logic [7:0] DIGIT_ONE = 8'h01;

  // Output word layout.
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned IN_TDATA_W  = 8;

  typedef struct packed {
    logic [NUM_SPEED-1:0][REG_W-1:0] speed_period;
    logic [REG_W-1:0]                blink_period;
  } lmss_cfg_t;

  typedef struct packed {
    logic               display_update;
    logic [SPEED_W-1:0] speed_sel;
    logic               blink_led;
    logic [7:0]         led_bar;
    logic [7:0]         digit_select;
    logic [7:0]         segment_pattern;
  } lmss_result_t;

  // Digit position p shows the glyph of the number p+1.
  function automatic logic [7:0] glyph_for_pos(input logic [POS_W-1:0] pos);
    logic [7:0] g;
    case (pos)
      3'd0:    g = 8'h06;
      3'd1:    g = 8'h5b;
      3'd2:    g = 8'h4f;
      3'd3:    g = 8'h66;
      3'd4:    g = 8'h6d;
      3'd5:    g = 8'h7d;
      3'd6:    g = 8'h07;
      3'd7:    g = 8'h7f;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

@@ rtl/lmss_cfg.sv @@
// Configuration register file of the LED marquee speed selector.
// Depends on lmss_pkg for register indexes, reset values and the config struct.
module lmss_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [lmss_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [lmss_pkg::REG_W-1:0]       cfg_wdata,
  output lmss_pkg::lmss_cfg_t              cfg_o
);

  lmss_pkg::lmss_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_addr)
        lmss_pkg::IDX_SPEED_PERIOD_0: cfg_nxt.speed_period[0] = cfg_wdata;
        lmss_pkg::IDX_SPEED_PERIOD_1: cfg_nxt.speed_period[1] = cfg_wdata;
        lmss_pkg::IDX_SPEED_PERIOD_2: cfg_nxt.speed_period[2] = cfg_wdata;
        lmss_pkg::IDX_SPEED_PERIOD_3: cfg_nxt.speed_period[3] = cfg_wdata;
        lmss_pkg::IDX_BLINK_PERIOD:   cfg_nxt.blink_period    = cfg_wdata;
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_period[0] <= lmss_pkg::RST_SPEED_PERIOD_0;
      cfg_r.speed_period[1] <= lmss_pkg::RST_SPEED_PERIOD_1;
      cfg_r.speed_period[2] <= lmss_pkg::RST_SPEED_PERIOD_2;
      cfg_r.speed_period[3] <= lmss_pkg::RST_SPEED_PERIOD_3;
      cfg_r.blink_period    <= lmss_pkg::RST_BLINK_PERIOD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

@@ rtl/lmss_core.sv @@
// Tick processing core: button edge detect, prescalers, blink and marquee state.
// Depends on lmss_pkg for the config and result structs and the glyph table.
module lmss_core #(
  parameter int unsigned TICKS_PER_FAST = 10,
  parameter int unsigned TICKS_PER_SLOW = 100
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  button_level,
  input  lmss_pkg::lmss_cfg_t   cfg,
  output lmss_pkg::lmss_result_t result_nxt
);

  localparam int unsigned FAST_W = $clog2(TICKS_PER_FAST);
  localparam int unsigned SLOW_W = $clog2(TICKS_PER_SLOW);
  localparam logic [FAST_W-1:0] FAST_RELOAD = FAST_W'(TICKS_PER_FAST - 1);
  localparam logic [SLOW_W-1:0] SLOW_RELOAD = SLOW_W'(TICKS_PER_SLOW - 1);
  localparam logic [FAST_W-1:0] FAST_ONE    = FAST_W'(1);
  localparam logic [SLOW_W-1:0] SLOW_ONE    = SLOW_W'(1);
  localparam logic [lmss_pkg::REG_W-1:0]   REG_ONE   = {{(lmss_pkg::REG_W-1){1'b0}}, 1'b1};
  localparam logic [lmss_pkg::POS_W-1:0]   POS_ONE   = {{(lmss_pkg::POS_W-1){1'b0}}, 1'b1};
  localparam logic [lmss_pkg::SPEED_W-1:0] SPEED_ONE = {{(lmss_pkg::SPEED_W-1){1'b0}}, 1'b1};

  logic [FAST_W-1:0]                fast_prescale_r, fast_prescale_nxt;
  logic [SLOW_W-1:0]                slow_prescale_r, slow_prescale_nxt;
  logic [lmss_pkg::REG_W-1:0]       blink_count_r, blink_count_nxt;
  logic [lmss_pkg::REG_W-1:0]       step_count_r, step_count_nxt;
  logic [lmss_pkg::POS_W-1:0]       position_r, position_nxt;
  logic                             second_digit_r, second_digit_nxt;
  logic [lmss_pkg::SPEED_W-1:0]     speed_index_r, speed_index_nxt;
  logic                             button_held_r, button_held_nxt;
  logic                             blink_level_r, blink_level_nxt;
  logic [7:0]                       segment_r, segment_nxt;
  logic [7:0]                       select_r, select_nxt;
  logic [7:0]                       led_r, led_nxt;

  logic                             fast_fire, slow_fire;
  logic [lmss_pkg::REG_W-1:0]       blink_inc, step_inc;
  logic [lmss_pkg::POS_W-1:0]       digit_pos;
  logic [15:0]                      pair_wide;

  always_comb begin
    button_held_nxt = button_held_r;
    speed_index_nxt = speed_index_r;
    if (!button_level) begin
      button_held_nxt = 1'b1;
    end else if (button_held_r) begin
      speed_index_nxt = speed_index_r + SPEED_ONE;
      button_held_nxt = 1'b0;
    end

    fast_fire         = (fast_prescale_r == '0);
    slow_fire         = (slow_prescale_r == '0);
    fast_prescale_nxt = fast_fire ? FAST_RELOAD : fast_prescale_r - FAST_ONE;
    slow_prescale_nxt = slow_fire ? SLOW_RELOAD : slow_prescale_r - SLOW_ONE;

    // Fast event: blink divider and display refresh.
    blink_inc        = blink_count_r + REG_ONE;
    blink_count_nxt  = blink_count_r;
    blink_level_nxt  = blink_level_r;
    segment_nxt      = segment_r;
    select_nxt       = select_r;
    led_nxt          = led_r;
    second_digit_nxt = second_digit_r;
    digit_pos        = position_r + lmss_pkg::POS_W'(second_digit_r);
    pair_wide        = {8'h00, lmss_pkg::LED_PAIR} << position_r;
    if (fast_fire) begin
      if (blink_inc >= cfg.blink_period) begin
        blink_count_nxt = '0;
        blink_level_nxt = ~blink_level_r;
      end else begin
        blink_count_nxt = blink_inc;
      end
      segment_nxt      = lmss_pkg::glyph_for_pos(digit_pos);
      select_nxt       = lmss_pkg::DIGIT_ONE << digit_pos;
      second_digit_nxt = ~second_digit_r;
      // The pair wraps from LED 7 back to LED 0.
      led_nxt          = ~(pair_wide[7:0] | pair_wide[15:8]);
    end

    // Slow event uses the speed index as already updated by this tick's button.
    step_inc       = step_count_r + REG_ONE;
    step_count_nxt = step_count_r;
    position_nxt   = position_r;
    if (slow_fire) begin
      if (step_inc >= cfg.speed_period[speed_index_nxt]) begin
        step_count_nxt = '0;
        position_nxt   = position_r + POS_ONE;
      end else begin
        step_count_nxt = step_inc;
      end
    end

    result_nxt.segment_pattern = segment_nxt;
    result_nxt.digit_select    = select_nxt;
    result_nxt.led_bar         = led_nxt;
    result_nxt.blink_led       = blink_level_nxt;
    result_nxt.speed_sel       = speed_index_nxt;
    result_nxt.display_update  = fast_fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_prescale_r <= FAST_RELOAD;
      slow_prescale_r <= SLOW_RELOAD;
      blink_count_r   <= '0;
      step_count_r    <= '0;
      position_r      <= '0;
      second_digit_r  <= 1'b0;
      speed_index_r   <= '0;
      button_held_r   <= 1'b0;
      blink_level_r   <= 1'b0;
      segment_r       <= '0;
      select_r        <= '0;
      led_r           <= lmss_pkg::LEDS_OFF;
    end else if (step) begin
      fast_prescale_r <= fast_prescale_nxt;
      slow_prescale_r <= slow_prescale_nxt;
      blink_count_r   <= blink_count_nxt;
      step_count_r    <= step_count_nxt;
      position_r      <= position_nxt;
      second_digit_r  <= second_digit_nxt;
      speed_index_r   <= speed_index_nxt;
      button_held_r   <= button_held_nxt;
      blink_level_r   <= blink_level_nxt;
      segment_r       <= segment_nxt;
      select_r        <= select_nxt;
      led_r           <= led_nxt;
    end
  end

endmodule

@@ rtl/led_marquee_speed_selector.sv @@
// LED marquee with speed selector. Each input word is one 1 ms tick carrying the
// active-low button level; every tick yields exactly one result word. One word is
// accepted per clock cycle when the output side keeps up. A word waits in the input
// register until the result register is free or being emptied; the step then moves it
// through the tick processing core into the result register, from which its result is
// presented on the output.
// Periods are set through the write port (indexes 0..3 speed periods, 4 blink).
// Depends on lmss_pkg, lmss_cfg and lmss_core.
module led_marquee_speed_selector #(
  parameter int unsigned TICKS_PER_FAST = 10,
  parameter int unsigned TICKS_PER_SLOW = 100
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // in_tdata: [0] button_level, [7:1] zero
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [lmss_pkg::IN_TDATA_W-1:0]       in_tdata,
  // out_tdata: [7:0] segment_pattern, [15:8] digit_select, [23:16] led_bar,
  // [24] blink_led, [26:25] speed_sel, [27] display_update, [31:28] zero
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [lmss_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  logic                                  cfg_wr_en,
  input  logic [lmss_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  logic [lmss_pkg::REG_W-1:0]            cfg_wdata
);

  localparam int unsigned RES_W = $bits(lmss_pkg::lmss_result_t);

  logic                   in_valid_r;
  logic                   level_r;
  logic                   out_valid_r;
  lmss_pkg::lmss_result_t out_data_r;
  lmss_pkg::lmss_result_t result_nxt;
  lmss_pkg::lmss_cfg_t    cfg;
  logic                   step;

  // The core advances when a word waits in the input register and the result
  // register is free or being emptied this cycle.
  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  lmss_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  lmss_core #(
    .TICKS_PER_FAST (TICKS_PER_FAST),
    .TICKS_PER_SLOW (TICKS_PER_SLOW)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .button_level (level_r),
    .cfg          (cfg),
    .result_nxt   (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      level_r <= in_tdata[0];
    end
    if (step) begin
      out_data_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(lmss_pkg::OUT_TDATA_W - RES_W)'(0), out_data_r};

  // A word must never be taken while the input register holds one that cannot move.
  a_no_input_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (!in_valid_r || step))
    else $error("input word accepted over a stalled word");

  // A refresh always drives exactly one digit.
  a_refresh_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.display_update) |-> $onehot(out_data_r.digit_select))
    else $error("display refresh without a single digit select");

  // A refresh always lights exactly two LEDs of the bar.
  a_refresh_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.display_update) |-> ($countones(out_data_r.led_bar) == 6))
    else $error("display refresh without exactly two lit LEDs");

  // Every step loads a fresh result that is presented on the next cycle.
  a_step_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("result register not loaded after a step");

endmodule
